>>> rtl/vrd_pkg.sv
`default_nettype none

package vrd_pkg;

  // 1/64 degree units: one full turn and the bias that makes any input positive
  localparam int DEG_TURN = 23040;
  localparam int DEG_BIAS = 3 * DEG_TURN;

  // u / 45 via reciprocal: q = (u * RECIP45) >> RECIP45_SHIFT, exact for u < 23040
  localparam int ZDIV          = 45;
  localparam int RECIP45       = 46604;
  localparam int RECIP45_SHIFT = 21;
  localparam int ZFRAC_W       = 23;
  localparam int Q_W           = 32 - ZFRAC_W;

  // inverse CORDIC gain, Q0.32
  localparam logic [31:0] KINV_Q32 = 32'd2608131496;

  localparam int ATAN_LEN = 24;
  localparam int OUT_W    = 17;

  typedef logic [0:ATAN_LEN-1][31:0] atan_tab_t;
  typedef logic [0:ZDIV-1][ZFRAC_W-1:0] zfrac_tab_t;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam atan_tab_t ATAN_TAB = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // fractional part of the binary angle for remainder r of u / 45:
  // floor((r * 2^23 + 22) / 45), built at elaboration
  function automatic zfrac_tab_t build_zfrac();
    zfrac_tab_t tab;
    longint     n;
    tab = '0;
    for (int r = 0; r < ZDIV; r++) begin
      n = (longint'(r) << ZFRAC_W) + 64'sd22;
      tab[r] = ZFRAC_W'(n / 45);
    end
    return tab;
  endfunction

  localparam zfrac_tab_t ZFRAC_TAB = build_zfrac();

endpackage

`default_nettype wire

>>> rtl/vrd_front.sv
`default_nettype none

module vrd_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] x_in,
  input  wire logic signed [15:0] y_in,
  input  wire logic signed [15:0] angle_deg,
  output logic                    out_valid,
  output logic signed [16:0]      x,
  output logic signed [16:0]      y,
  output logic signed [31:0]      z
);
  import vrd_pkg::*;

  // stage 0: angle modulo one turn
  logic signed [17:0] t_full;
  logic [16:0]        t;
  logic [14:0]        u_next;
  logic               v0;
  logic [14:0]        u0;
  logic signed [15:0] x0, y0;

  assign t_full = 18'(angle_deg) + 18'(DEG_BIAS);
  assign t      = t_full[16:0];

  always_comb begin
    if (t >= 17'(4 * DEG_TURN)) begin
      u_next = 15'(t - 17'(4 * DEG_TURN));
    end else if (t >= 17'(3 * DEG_TURN)) begin
      u_next = 15'(t - 17'(3 * DEG_TURN));
    end else if (t >= 17'(2 * DEG_TURN)) begin
      u_next = 15'(t - 17'(2 * DEG_TURN));
    end else begin
      u_next = 15'(t - 17'(DEG_TURN));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    u0 <= u_next;
    x0 <= x_in;
    y0 <= y_in;
  end

  // stage 1: quotient u / 45
  logic [30:0]        qprod;
  logic               v1;
  logic [14:0]        u1;
  logic [Q_W-1:0]     q1;
  logic signed [15:0] x1, y1;

  assign qprod = 31'(u0) * 31'(RECIP45);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    u1 <= u0;
    q1 <= qprod[RECIP45_SHIFT +: Q_W];
    x1 <= x0;
    y1 <= y0;
  end

  // stage 2: binary angle, then fold into [-90, +90] degrees
  logic [14:0]        q45;
  logic [14:0]        rem;
  logic [5:0]         r;
  logic signed [31:0] zb;
  logic               fold;
  logic signed [16:0] x1e, y1e;

  assign q45  = 15'(q1) * 15'(ZDIV);
  assign rem  = u1 - q45;
  assign r    = rem[5:0];
  assign zb   = $signed({q1, ZFRAC_TAB[r]});
  assign fold = (zb > 32'sd1073741824) || (zb < -32'sd1073741824);
  assign x1e  = 17'(x1);
  assign y1e  = 17'(y1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v1;
    end
  end

  // a move of half a turn is a flip of the sign bit of the binary angle
  always_ff @(posedge clk) begin
    z <= {zb[31] ^ fold, zb[30:0]};
    x <= fold ? -x1e : x1e;
    y <= fold ? -y1e : y1e;
  end

`ifndef SYNTH
  a_turn_range : assert property (@(posedge clk) disable iff (rst)
    v0 |-> (u0 < 15'(DEG_TURN)))
    else $error("reduced angle out of one turn");

  a_rem_range : assert property (@(posedge clk) disable iff (rst)
    v1 |-> (rem < 15'(ZDIV)))
    else $error("reciprocal quotient off by one");

  a_fold_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((z >= -32'sd1073741824) && (z <= 32'sd1073741824)))
    else $error("folded angle beyond quarter turn");
`endif

endmodule

`default_nettype wire

>>> rtl/vrd_scale.sv
`default_nettype none

module vrd_scale #(
  parameter int DATA_WIDTH = 16,
  parameter int W          = DATA_WIDTH + 18
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [16:0] x_in,
  input  wire logic signed [16:0] y_in,
  input  wire logic signed [31:0] z_in,
  output logic                    out_valid,
  output logic signed [W-1:0]     x,
  output logic signed [W-1:0]     y,
  output logic signed [31:0]      z
);
  import vrd_pkg::*;

  localparam int PW = 50;

  logic signed [PW-1:0] kinv;
  logic signed [PW-1:0] px, py;

  // 17 x 33 signed multiply, then floor shift down to DATA_WIDTH+8 fraction bits
  assign kinv = $signed({18'd0, KINV_Q32});
  assign px   = PW'(x_in) * kinv;
  assign py   = PW'(y_in) * kinv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x <= W'(px >>> (32 - DATA_WIDTH));
    y <= W'(py >>> (32 - DATA_WIDTH));
    z <= z_in;
  end

endmodule

`default_nettype wire

>>> rtl/vrd_rot.sv
`default_nettype none

module vrd_rot #(
  parameter int          W     = 34,
  parameter int          SHIFT = 0,
  parameter logic [31:0] ATAN  = 32'd0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [W-1:0] x_in,
  input  wire logic signed [W-1:0] y_in,
  input  wire logic signed [31:0] z_in,
  output logic                    out_valid,
  output logic signed [W-1:0]     x,
  output logic signed [W-1:0]     y,
  output logic signed [31:0]      z
);

  logic signed [W-1:0] xs, ys;
  logic                ccw;

  assign xs  = x_in >>> SHIFT;
  assign ys  = y_in >>> SHIFT;
  assign ccw = !z_in[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x <= ccw ? x_in - ys : x_in + ys;
    y <= ccw ? y_in + xs : y_in - xs;
    z <= ccw ? z_in - $signed(ATAN) : z_in + $signed(ATAN);
  end

endmodule

`default_nettype wire

>>> rtl/vector_rotate_by_degrees_core.sv
`default_nettype none

// Vector rotation by an angle in degrees, pipelined CORDIC in rotation mode.
//
// Request: x_in, y_in (signed Q8.8) and angle_deg (signed, 1/64 degree,
// counterclockwise positive) are taken at a rising edge with start high and
// busy low. busy is high only during reset; otherwise a request can be
// issued every cycle, so throughput is one vector per clock.
// Result: x_out, y_out (17-bit signed Q9.8, rounded to nearest) are valid
// for the single cycle in which done is high. There is no back-pressure;
// the receiver must take the result in that cycle.
// Pipeline: three front stages (angle modulo, divide by 45 via reciprocal,
// binary angle and quadrant fold), one gain pre-scale multiply, one stage
// per micro-rotation, one rounding stage.
// Reset (synchronous, rst high) clears every stage valid bit; requests
// in flight are dropped and done stays low until new requests come out.
// No state is carried between requests.
module vector_rotate_by_degrees_core #(
  parameter int ITERATIONS = 16,
  parameter int DATA_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] x_in,
  input  wire logic signed [15:0] y_in,
  input  wire logic signed [15:0] angle_deg,
  output logic                    done,
  output logic signed [16:0]      x_out,
  output logic signed [16:0]      y_out
);
  import vrd_pkg::*;

  // datapath width: Q8.8 input with DATA_WIDTH extra fraction bits, plus
  // headroom for the sqrt(2) worst-case magnitude growth
  localparam int W   = DATA_WIDTH + 18;
  localparam int LAT = ITERATIONS + 5;

  logic req;

  // pipeline is never stalled; hold off only while in reset
  assign busy = rst;
  assign req  = start && !busy;

  // front end: angle reduction, binary angle, fold
  logic               f_valid;
  logic signed [16:0] f_x, f_y;
  logic signed [31:0] f_z;

  vrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req),
    .x_in      (x_in),
    .y_in      (y_in),
    .angle_deg (angle_deg),
    .out_valid (f_valid),
    .x         (f_x),
    .y         (f_y),
    .z         (f_z)
  );

  // rotation chain: index 0 is the pre-scaled vector
  logic [ITERATIONS:0]        rv;
  logic signed [W-1:0]        rx [ITERATIONS+1];
  logic signed [W-1:0]        ry [ITERATIONS+1];
  logic signed [31:0]         rz [ITERATIONS+1];

  vrd_scale #(
    .DATA_WIDTH (DATA_WIDTH),
    .W          (W)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .x_in      (f_x),
    .y_in      (f_y),
    .z_in      (f_z),
    .out_valid (rv[0]),
    .x         (rx[0]),
    .y         (ry[0]),
    .z         (rz[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    vrd_rot #(
      .W     (W),
      .SHIFT (i),
      .ATAN  (ATAN_TAB[i])
    ) u_rot (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (rv[i]),
      .x_in      (rx[i]),
      .y_in      (ry[i]),
      .z_in      (rz[i]),
      .out_valid (rv[i+1]),
      .x         (rx[i+1]),
      .y         (ry[i+1]),
      .z         (rz[i+1])
    );
  end

  // output rounding: add half an LSB, floor shift, keep 17 bits
  logic signed [W-1:0] xr, yr;
  logic signed [W-1:0] half;

  assign half = W'(1) <<< (DATA_WIDTH - 1);
  assign xr   = rx[ITERATIONS] + half;
  assign yr   = ry[ITERATIONS] + half;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rv[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    x_out <= OUT_W'(xr >>> DATA_WIDTH);
    y_out <= OUT_W'(yr >>> DATA_WIDTH);
  end

`ifndef SYNTH
  a_req_done : assert property (@(posedge clk) disable iff (rst)
    req |-> ##LAT done)
    else $error("request without result");

  a_idle_quiet : assert property (@(posedge clk) disable iff (rst)
    !req |-> ##LAT !done)
    else $error("result without request");

  a_reset_clear : assert property (@(posedge clk)
    rst |=> !done)
    else $error("done high after reset");
`endif

endmodule

`default_nettype wire

>>> bench/vector_rotate_by_degrees_core_tb.sv
`timescale 1ns / 100ps

module vector_rotate_by_degrees_core_tb;

  localparam int ITERATIONS = 16;
  localparam int DATA_WIDTH = 16;

  // Angle units: 1/64 degree, so one turn is 360 * 64.
  localparam longint TURN_UNITS      = 64'sd23040;
  localparam longint HALF_TURN_UNITS = 64'sd11520;
  localparam int     QUARTER_UNITS   = 5760;
  // Inverse CORDIC gain, Q0.32; same value for any iteration count.
  localparam longint GAIN_INV_Q32    = 64'sd2608131496;
  localparam int     ARCTAN_LEN      = 24;

  localparam int NUM_RANDOM   = 1100;
  // Pipeline is ITERATIONS + 5 deep; the tail wait covers it with margin.
  localparam int TAIL_CYCLES  = ITERATIONS + 12;
  // Longest idle stretch allowed; it exceeds the largest sender gap and a full pipeline drain.
  localparam int STALL_LIMIT  = 4000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] ang;
    bit                 drain;  // hold this request until the pipe is empty
  } rot_req_t;

  typedef struct {
    logic signed [16:0] x;
    logic signed [16:0] y;
  } rot_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [15:0] x_in = '0;
  logic signed [15:0] y_in = '0;
  logic signed [15:0] angle_deg = '0;
  logic busy;
  logic done;
  logic signed [16:0] x_out;
  logic signed [16:0] y_out;

  rot_req_t pending_reqs[$];
  rot_res_t rotated_q[$];

  int err_count = 0;
  int gap_left = 0;
  int calm_left = 0;
  int stall_cycles = 0;

  vector_rotate_by_degrees_core #(
    .ITERATIONS(ITERATIONS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .x_in     (x_in),
    .y_in     (y_in),
    .angle_deg(angle_deg),
    .done     (done),
    .x_out    (x_out),
    .y_out    (y_out)
  );

  always #1 clk = ~clk;

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // atan(2^-i) as a binary angle, 2^32 per turn
  function automatic longint arctan_step(int i);
    case (i)
      0:  return 64'sd536870912;
      1:  return 64'sd316933406;
      2:  return 64'sd167458907;
      3:  return 64'sd85004756;
      4:  return 64'sd42667331;
      5:  return 64'sd21354465;
      6:  return 64'sd10679838;
      7:  return 64'sd5340245;
      8:  return 64'sd2670163;
      9:  return 64'sd1335087;
      10: return 64'sd667544;
      11: return 64'sd333772;
      12: return 64'sd166886;
      13: return 64'sd83443;
      14: return 64'sd41722;
      15: return 64'sd20861;
      16: return 64'sd10430;
      17: return 64'sd5215;
      18: return 64'sd2608;
      19: return 64'sd1304;
      20: return 64'sd652;
      21: return 64'sd326;
      22: return 64'sd163;
      default: return 64'sd81;
    endcase
  endfunction

  // Bit-exact CORDIC rotation. All shifts on signed longint are arithmetic,
  // which gives floor division by powers of two.
  function automatic rot_res_t cordic_expect(logic signed [15:0] xi, logic signed [15:0] yi,
                                             logic signed [15:0] ang);
    longint vx, vy, vz, u, zb, sx, sy;
    rot_res_t r;
    vx = xi;
    vy = yi;
    // reduce to [0, one turn), then to a 32-bit binary angle, rounded
    u  = (longint'(ang) + 3 * TURN_UNITS) % TURN_UNITS;
    zb = ((u <<< 32) + HALF_TURN_UNITS) / TURN_UNITS;
    vz = (zb >= 64'sh8000_0000) ? zb - (64'sd1 <<< 32) : zb;
    // fold beyond +-90 degrees: shift by half a turn, negate the vector
    if (vz > (64'sd1 <<< 30)) begin
      vz = vz - (64'sd1 <<< 31);
      vx = -vx;
      vy = -vy;
    end else if (vz < -(64'sd1 <<< 30)) begin
      vz = vz + (64'sd1 <<< 31);
      vx = -vx;
      vy = -vy;
    end
    vx = (vx * GAIN_INV_Q32) >>> (32 - DATA_WIDTH);
    vy = (vy * GAIN_INV_Q32) >>> (32 - DATA_WIDTH);
    for (int i = 0; i < ITERATIONS && i < ARCTAN_LEN; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vz >= 0) begin
        vx = vx - sy;
        vy = vy + sx;
        vz = vz - arctan_step(i);
      end else begin
        vx = vx + sy;
        vy = vy - sx;
        vz = vz + arctan_step(i);
      end
    end
    // round half up back to 8 fraction bits (Q9.8), keep 17 bits
    r.x = 17'((vx + (64'sd1 <<< (DATA_WIDTH - 1))) >>> DATA_WIDTH);
    r.y = 17'((vy + (64'sd1 <<< (DATA_WIDTH - 1))) >>> DATA_WIDTH);
    return r;
  endfunction

  // Q8.8 component, biased toward the extremes and zero
  function automatic logic signed [15:0] pick_component();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8)       return 16'sh8000;
    else if (sel < 16) return 16'sh7fff;
    else if (sel < 20) return '0;
    else if (sel < 30) return 16'($signed($urandom_range(0, 1023)) - 512);
    else               return 16'($urandom);
  endfunction

  // Angle, often near a multiple of 90 degrees where the fold switches
  function automatic logic signed [15:0] pick_angle();
    int k;
    int off;
    if ($urandom_range(0, 99) < 25) begin
      k   = $signed($urandom_range(0, 10)) - 5;
      off = $signed($urandom_range(0, 2)) - 1;
      return 16'(k * QUARTER_UNITS + off);
    end
    return 16'($urandom);
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60)      return 0;
    else if (sel < 90) return $urandom_range(1, 3);
    else if (sel < 98) return $urandom_range(4, 20);
    else               return $urandom_range(21, 100);
  endfunction

  function automatic rot_req_t make_req(int xv, int yv, int av, bit drain);
    rot_req_t q;
    q.x     = 16'(xv);
    q.y     = 16'(yv);
    q.ang   = 16'(av);
    q.drain = drain;
    return q;
  endfunction

  // Driver: a request is taken at an edge where start is high and busy low.
  // The expectation is pushed at that edge from the values still on the pins.
  // start gets exactly one nonblocking update per edge.
  always @(posedge clk) begin
    logic     taken;
    logic     next_start;
    rot_req_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken      = start && !busy;
      next_start = start && !taken;
      if (taken) rotated_q.push_back(cordic_expect(x_in, y_in, angle_deg));
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && rotated_q.size() != 0)) begin
          nxt = pending_reqs.pop_front();
          x_in      <= nxt.x;
          y_in      <= nxt.y;
          angle_deg <= nxt.ang;
          next_start = 1'b1;
          // calm stretches give back-to-back requests through the whole pipe
          if (calm_left > 0) begin
            calm_left--;
            gap_left = 0;
          end else begin
            gap_left = pick_gap();
            if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 80);
          end
        end
      end
      start <= next_start;
    end
  end

  // Monitor: done marks a one-cycle result that must be taken at this edge.
  always @(posedge clk) begin
    rot_res_t want;
    if (!rst && done) begin
      if (rotated_q.size() == 0) begin
        flag_error($sformatf("result with nothing outstanding: x=%0d y=%0d", x_out, y_out));
      end else begin
        want = rotated_q.pop_front();
        if (x_out !== want.x)
          flag_error($sformatf("x_out got %0d want %0d", x_out, want.x));
        if (y_out !== want.y)
          flag_error($sformatf("y_out got %0d want %0d", y_out, want.y));
      end
    end
  end

  // Watchdog: idle cycles with neither a request nor a result taken.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // directed: zero, full-scale vectors, every fold region, wrap limits
    pending_reqs.push_back(make_req(0, 0, 0, 0));
    pending_reqs.push_back(make_req(32767, 0, 0, 0));
    pending_reqs.push_back(make_req(32767, 0, 5760, 0));      // exactly +90, no fold
    pending_reqs.push_back(make_req(32767, 0, 5761, 0));      // just past +90, folds
    pending_reqs.push_back(make_req(32767, 0, -5760, 0));     // exactly -90
    pending_reqs.push_back(make_req(32767, 0, -5761, 0));
    pending_reqs.push_back(make_req(256, 512, 11520, 0));     // 180 folds to 0 negated
    pending_reqs.push_back(make_req(256, 512, -11520, 0));
    pending_reqs.push_back(make_req(-32768, 0, 17280, 0));    // 270
    pending_reqs.push_back(make_req(-32768, 32767, 23040, 0)); // one full turn
    pending_reqs.push_back(make_req(1000, -1000, 32767, 0));  // max angle, beyond a turn
    pending_reqs.push_back(make_req(1000, -1000, -32768, 0)); // min angle
    pending_reqs.push_back(make_req(-32768, -32768, 2880, 0)); // largest magnitude at 45
    pending_reqs.push_back(make_req(-32768, -32768, 8640, 0)); // 135
    pending_reqs.push_back(make_req(-32768, -32768, -8640, 0));
    pending_reqs.push_back(make_req(32767, 32767, -2880, 0));
    pending_reqs.push_back(make_req(0, -32768, 1, 0));        // smallest angle step
    pending_reqs.push_back(make_req(0, -32768, -1, 0));
    pending_reqs.push_back(make_req(1, -1, 11519, 0));
    pending_reqs.push_back(make_req(-1, 1, 11521, 0));
    pending_reqs.push_back(make_req(32767, -32768, 28800, 1)); // wait for an empty pipe

    // random: mostly biased fields, a few requests held until everything is back
    for (int n = 0; n < NUM_RANDOM; n++)
      pending_reqs.push_back(make_req(pick_component(), pick_component(), pick_angle(),
                                      (n == 300 || n == 700)));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || start || rotated_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (rotated_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", rotated_q.size()));
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/vrd_pkg.sv
rtl/vrd_front.sv
rtl/vrd_scale.sv
rtl/vrd_rot.sv
rtl/vector_rotate_by_degrees_core.sv
bench/vector_rotate_by_degrees_core_tb.sv
